>>> hw/rtl/sgg_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sgg_pkg: shared types and constants for the spectral Gaussian gain block
// Item layouts, register indexes and the request/response between the main
// pipeline and the exponential lookup.
// ----------------------------------------------------------------------------
package sgg_pkg;

	localparam int unsigned EXP_TABLE_ENTRIES_DEF = 256;
	localparam logic [16:0] MAX_GRID_SIZE         = 17'd4096;

	localparam int unsigned FREQ_W  = 12;
	localparam int unsigned GRID_W  = 13;
	localparam int unsigned DATA_W  = 32;
	localparam int unsigned S_W     = 28;   // s below 16.0 in Q.24
	localparam int unsigned E_W     = 17;   // Q0.16, one included
	localparam int unsigned CFG_IDX_W = 3;

	// cycles from request to response in the exponential unit
	localparam int unsigned EXP_LAT = 4;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_GRID_X  = 3'd0,
		REG_GRID_Y  = 3'd1,
		REG_GRID_Z  = 3'd2,
		REG_WIDTH_X = 3'd3,
		REG_WIDTH_Y = 3'd4,
		REG_WIDTH_Z = 3'd5,
		REG_GAIN    = 3'd6
	} cfg_reg_t;

	typedef struct packed {
		logic [FREQ_W-1:0]        freq_x;
		logic [FREQ_W-1:0]        freq_y;
		logic [FREQ_W-1:0]        freq_z;
		logic signed [DATA_W-1:0] coef_re;
		logic signed [DATA_W-1:0] coef_im;
	} sgg_in_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] out_re;
		logic signed [DATA_W-1:0] out_im;
	} sgg_out_t;

	typedef struct packed {
		logic           valid;
		logic           sat;
		logic [S_W-1:0] s;
	} exp_req_t;

	typedef struct packed {
		logic           valid;
		logic [E_W-1:0] e;
	} exp_rsp_t;

endpackage
`default_nettype wire

>>> hw/rtl/sgg_exp.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sgg_exp: pipelined exp(-s) lookup
// Table of exp(-j*16/N) in Q0.30 with linear interpolation, four stages,
// result in Q0.16 and forced to zero when s has saturated.
// ----------------------------------------------------------------------------
module sgg_exp
	import sgg_pkg::*;
#(
	parameter int unsigned EXP_TABLE_ENTRIES = EXP_TABLE_ENTRIES_DEF
) (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire exp_req_t req,
	output exp_rsp_t      rsp
);

	localparam int unsigned IW = $clog2(EXP_TABLE_ENTRIES);
	localparam int unsigned TW = $clog2(EXP_TABLE_ENTRIES + 1);
	localparam int unsigned PW = S_W + TW;
	localparam logic [63:0] EXP_X = (64'd16 << 30) / EXP_TABLE_ENTRIES;

	typedef logic [30:0] tab_t [EXP_TABLE_ENTRIES+1];

	function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
		logic [63:0] rem;
		logic [63:0] quo;
		rem = '0;
		quo = '0;
		for (int b = 63; b >= 0; b--) begin
			rem = {rem[62:0], num[b]};
			if (rem >= den) begin
				rem    = rem - den;
				quo[b] = 1'b1;
			end
		end
		return quo;
	endfunction

	function automatic tab_t build_tab();
		logic [63:0] term;
		logic [63:0] sum;
		logic [63:0] t;
		tab_t        tb;
		term = 64'd1 << 30;
		sum  = term;
		for (int j = 1; j <= 24; j++) begin
			term = (term * EXP_X) >> 30;
			term = udiv64(term, 64'(j));
			if (j % 2 == 1) begin
				sum = sum - term;
			end else begin
				sum = sum + term;
			end
		end
		tb[0] = 31'd1 << 30;
		for (int j = 1; j <= int'(EXP_TABLE_ENTRIES); j++) begin
			t     = {33'd0, tb[j-1]} * sum + (64'd1 << 29);
			tb[j] = t[60:30];
		end
		return tb;
	endfunction

	localparam tab_t EXP_TAB = build_tab();

	// s5: position in table
	logic [PW-1:0] p;
	logic          valid_s5, sat_s5;
	logic [IW-1:0] idx_s5;
	logic [23:0]   frac_s5;

	assign p = PW'(req.s) * PW'(EXP_TABLE_ENTRIES);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s5 <= 1'b0;
		end else begin
			valid_s5 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		sat_s5  <= req.sat;
		idx_s5  <= p[S_W +: IW];
		frac_s5 <= p[27:4];
	end

	// s6: table read
	logic [TW-1:0] idx_a, idx_b;
	logic          valid_s6, sat_s6;
	logic [30:0]   a_s6, b_s6;
	logic [23:0]   frac_s6;

	assign idx_a = TW'(idx_s5);
	assign idx_b = idx_a + TW'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s6 <= 1'b0;
		end else begin
			valid_s6 <= valid_s5;
		end
	end

	always_ff @(posedge clk) begin
		sat_s6  <= sat_s5;
		a_s6    <= EXP_TAB[idx_a];
		b_s6    <= EXP_TAB[idx_b];
		frac_s6 <= frac_s5;
	end

	// s7: slope times fraction
	logic        valid_s7, sat_s7;
	logic [30:0] a_s7;
	logic [54:0] prod_s7;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s7 <= 1'b0;
		end else begin
			valid_s7 <= valid_s6;
		end
	end

	always_ff @(posedge clk) begin
		sat_s7  <= sat_s6;
		a_s7    <= a_s6;
		prod_s7 <= 55'(a_s6 - b_s6) * 55'(frac_s6);
	end

	// s8: interpolate and round to Q0.16
	logic [30:0]    e30, e_rnd;
	logic           valid_s8;
	logic [E_W-1:0] e_s8;

	assign e30   = a_s7 - prod_s7[54:24];
	assign e_rnd = e30 + 31'(1 << 13);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s8 <= 1'b0;
		end else begin
			valid_s8 <= valid_s7;
		end
	end

	always_ff @(posedge clk) begin
		e_s8 <= sat_s7 ? '0 : e_rnd[30:14];
	end

	assign rsp.valid = valid_s8;
	assign rsp.e     = e_s8;

endmodule
`default_nettype wire

>>> hw/rtl/spectral_gaussian_gain.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// spectral_gaussian_gain: Gaussian smoothing gain on Fourier coefficients
// Folds the 3-D frequency index to wavenumbers, forms the Gaussian exponent,
// looks up exp(-s) and scales the complex coefficient by gain*exp(-s).
//
//   channel  signals                       handshake
//   input    sample (sgg_in_t)             start & !busy
//   result   result (sgg_out_t)            done, one cycle, no back-pressure
//   config   cfg_we, cfg_index, cfg_data   cfg_we, immediate
//
// One item per cycle; the pipeline depth is set by the
// chain of multipliers (square, weight, table position, interpolation, gain,
// coefficient), each with its own register stage.
// busy stays low: the pipeline never stalls.
// Reset clears the valid bits and loads the register defaults.
// ----------------------------------------------------------------------------
module spectral_gaussian_gain
	import sgg_pkg::*;
#(
	parameter int unsigned EXP_TABLE_ENTRIES = EXP_TABLE_ENTRIES_DEF
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 start,
	output logic                      busy,
	input  wire sgg_in_t              sample,
	output logic                      done,
	output sgg_out_t                  result,
	input  wire logic                 cfg_we,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [DATA_W-1:0]    cfg_data
);

	function automatic logic signed [13:0] fold_idx(input logic [FREQ_W-1:0] k,
			input logic [GRID_W-1:0] grid);
		logic [16:0] n;
		n = ({4'd0, grid} > MAX_GRID_SIZE) ? MAX_GRID_SIZE : {4'd0, grid};
		if ({4'd0, k, 1'b0} > n) begin
			return $signed({2'b00, k}) - $signed({1'b0, n[12:0]});
		end
		return $signed({2'b00, k});
	endfunction

	// configuration registers
	logic [GRID_W-1:0] grid_x_q, grid_y_q, grid_z_q;
	logic [DATA_W-1:0] width_x_q, width_y_q, width_z_q, gain_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_x_q  <= GRID_W'(256);
			grid_y_q  <= GRID_W'(256);
			grid_z_q  <= GRID_W'(256);
			width_x_q <= '0;
			width_y_q <= '0;
			width_z_q <= '0;
			gain_q    <= '1;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_GRID_X:  grid_x_q  <= cfg_data[GRID_W-1:0];
				REG_GRID_Y:  grid_y_q  <= cfg_data[GRID_W-1:0];
				REG_GRID_Z:  grid_z_q  <= cfg_data[GRID_W-1:0];
				REG_WIDTH_X: width_x_q <= cfg_data;
				REG_WIDTH_Y: width_y_q <= cfg_data;
				REG_WIDTH_Z: width_z_q <= cfg_data;
				REG_GAIN:    gain_q    <= cfg_data;
				default: ;
			endcase
		end
	end

	assign busy = 1'b0;

	logic accept;
	assign accept = start && !busy;

	// valid chain
	logic valid_s1, valid_s2, valid_s3, valid_s4;
	logic valid_s9, valid_s10, valid_s11, valid_s12;
	exp_req_t exp_req;
	exp_rsp_t exp_rsp;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1  <= 1'b0;
			valid_s2  <= 1'b0;
			valid_s3  <= 1'b0;
			valid_s4  <= 1'b0;
			valid_s9  <= 1'b0;
			valid_s10 <= 1'b0;
			valid_s11 <= 1'b0;
			valid_s12 <= 1'b0;
		end else begin
			valid_s1  <= accept;
			valid_s2  <= valid_s1;
			valid_s3  <= valid_s2;
			valid_s4  <= valid_s3;
			valid_s9  <= exp_rsp.valid;
			valid_s10 <= valid_s9;
			valid_s11 <= valid_s10;
			valid_s12 <= valid_s11;
		end
	end

	// s1: fold to wavenumbers
	logic signed [13:0] kx_s1, ky_s1, kz_s1;
	logic [2*DATA_W-1:0] coef_s1, coef_s2, coef_s3, coef_s4;

	always_ff @(posedge clk) begin
		kx_s1   <= fold_idx(sample.freq_x, grid_x_q);
		ky_s1   <= fold_idx(sample.freq_y, grid_y_q);
		kz_s1   <= fold_idx(sample.freq_z, grid_z_q);
		coef_s1 <= {sample.coef_re, sample.coef_im};
	end

	// s2: squares
	logic signed [27:0] sqx, sqy, sqz;
	logic [25:0]        kkx_s2, kky_s2, kkz_s2;

	assign sqx = kx_s1 * kx_s1;
	assign sqy = ky_s1 * ky_s1;
	assign sqz = kz_s1 * kz_s1;

	always_ff @(posedge clk) begin
		kkx_s2  <= sqx[25:0];
		kky_s2  <= sqy[25:0];
		kkz_s2  <= sqz[25:0];
		coef_s2 <= coef_s1;
	end

	// s3: weighted squares
	logic [57:0] wx_s3, wy_s3, wz_s3;

	always_ff @(posedge clk) begin
		wx_s3   <= 58'(kkx_s2) * 58'(width_x_q);
		wy_s3   <= 58'(kky_s2) * 58'(width_y_q);
		wz_s3   <= 58'(kkz_s2) * 58'(width_z_q);
		coef_s3 <= coef_s2;
	end

	// s4: exponent s = sum / 2, saturation at 16.0
	logic [59:0]    acc;
	logic           sat_s4;
	logic [S_W-1:0] s_s4;

	assign acc = 60'(wx_s3) + 60'(wy_s3) + 60'(wz_s3);

	always_ff @(posedge clk) begin
		sat_s4  <= |acc[59:S_W+1];
		s_s4    <= acc[S_W:1];
		coef_s4 <= coef_s3;
	end

	assign exp_req.valid = valid_s4;
	assign exp_req.sat   = sat_s4;
	assign exp_req.s     = s_s4;

	sgg_exp #(
		.EXP_TABLE_ENTRIES(EXP_TABLE_ENTRIES)
	) u_exp (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (exp_req),
		.rsp   (exp_rsp)
	);

	// coefficient travels alongside the exponential unit
	logic [2*DATA_W-1:0] coef_exp_s [EXP_LAT];

	always_ff @(posedge clk) begin
		coef_exp_s[0] <= coef_s4;
		for (int i = 1; i < int'(EXP_LAT); i++) begin
			coef_exp_s[i] <= coef_exp_s[i-1];
		end
	end

	// s9: gain times exponential
	logic [48:0]         ge_s9;
	logic [2*DATA_W-1:0] coef_s9, coef_s10;

	always_ff @(posedge clk) begin
		ge_s9   <= 49'(gain_q) * 49'(exp_rsp.e);
		coef_s9 <= coef_exp_s[EXP_LAT-1];
	end

	// s10: round to Q0.32
	logic [48:0]       ge_rnd;
	logic [DATA_W-1:0] g_s10;

	assign ge_rnd = ge_s9 + 49'(1 << 15);

	always_ff @(posedge clk) begin
		g_s10    <= ge_rnd[47:16];
		coef_s10 <= coef_s9;
	end

	// s11: scale both parts
	logic signed [64:0] pre_s11, pim_s11;

	always_ff @(posedge clk) begin
		pre_s11 <= 65'($signed(coef_s10[2*DATA_W-1:DATA_W])) * $signed({33'd0, g_s10});
		pim_s11 <= 65'($signed(coef_s10[DATA_W-1:0])) * $signed({33'd0, g_s10});
	end

	// s12: round, floor shift, saturate
	function automatic logic signed [DATA_W-1:0] round_sat(input logic signed [64:0] p);
		logic signed [64:0] t;
		logic signed [32:0] q;
		t = p + 65'sd2147483648;
		q = t[64:32];
		if (q > 33'sd2147483647) begin
			return 32'sh7FFFFFFF;
		end
		if (q < -33'sd2147483648) begin
			return 32'sh80000000;
		end
		return q[DATA_W-1:0];
	endfunction

	sgg_out_t result_s12;

	always_ff @(posedge clk) begin
		result_s12.out_re <= round_sat(pre_s11);
		result_s12.out_im <= round_sat(pim_s11);
	end

	assign done   = valid_s12;
	assign result = result_s12;

endmodule
`default_nettype wire

>>> verif/spectral_gaussian_gain_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spectral_gaussian_gain_checker: result predictor and comparator
// Follows register writes and accepted items, works out the filtered
// coefficient for each item and compares it with the next result strobed out.
// Reports the mismatch count and the number of results still outstanding.
// ----------------------------------------------------------------------------
module spectral_gaussian_gain_checker
	import sgg_pkg::*;
#(
	parameter int unsigned EXP_TABLE_ENTRIES = EXP_TABLE_ENTRIES_DEF
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 start,
	input  wire logic                 busy,
	input  wire sgg_in_t              sample,
	input  wire logic                 done,
	input  wire sgg_out_t             result,
	input  wire logic                 cfg_we,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [DATA_W-1:0]    cfg_data,
	output int                        errors,
	output int                        pending
);

	localparam longint unsigned SAT_S = 64'd16 << 24;

	longint unsigned exp_lut [0:EXP_TABLE_ENTRIES];

	logic [GRID_W-1:0] grid_x, grid_y, grid_z;
	logic [31:0]       width_x, width_y, width_z, fft_gain;

	sgg_out_t filtered_q [$];
	int       mismatches = 0;

	assign errors = mismatches;

	initial begin : build_lut
		longint unsigned step, term, series;
		int j;
		step   = (64'd16 << 30) / EXP_TABLE_ENTRIES;
		term   = 64'd1 << 30;
		series = term;
		for (j = 1; j <= 24; j++) begin
			term = (term * step) >> 30;
			term = term / j;
			if (j % 2)
				series = series - term;
			else
				series = series + term;
		end
		exp_lut[0] = 64'd1 << 30;
		for (j = 1; j <= EXP_TABLE_ENTRIES; j++)
			exp_lut[j] = (exp_lut[j-1] * series + (64'd1 << 29)) >> 30;
	end

	function automatic longint unsigned wavenum_sq(logic [FREQ_W-1:0] idx,
			logic [GRID_W-1:0] n);
		longint k, nn;
		k  = longint'(idx);
		nn = (n > MAX_GRID_SIZE) ? longint'(MAX_GRID_SIZE) : longint'(n);
		if (2 * k > nn)
			k = k - nn;
		return longint'(k * k);
	endfunction

	// exp(-s) in Q0.16, s in Q.24
	function automatic longint unsigned gauss_exp_q16(longint unsigned s);
		longint unsigned pos, idx, frac, a, b, e30;
		if (s >= SAT_S)
			return 0;
		pos  = (s * EXP_TABLE_ENTRIES) >> 4;
		idx  = pos >> 24;
		frac = pos & 64'hFF_FFFF;
		if (idx >= EXP_TABLE_ENTRIES) begin
			idx  = EXP_TABLE_ENTRIES - 1;
			frac = 64'hFF_FFFF;
		end
		a   = exp_lut[idx];
		b   = exp_lut[idx+1];
		e30 = a - (((a - b) * frac) >> 24);
		return (e30 + 64'd8192) >> 14;
	endfunction

	function automatic logic signed [DATA_W-1:0] scale_part(logic signed [DATA_W-1:0] c,
			longint unsigned g);
		longint p, q;
		p = longint'(c) * longint'(g) + (64'sd1 <<< 31);
		q = p >>> 32;
		if (q > 64'sd2147483647)
			q = 64'sd2147483647;
		if (q < -64'sd2147483648)
			q = -64'sd2147483648;
		return q[DATA_W-1:0];
	endfunction

	function automatic sgg_out_t filter_coef(sgg_in_t it);
		longint unsigned acc, g;
		sgg_out_t r;
		acc = wavenum_sq(it.freq_x, grid_x) * width_x
			+ wavenum_sq(it.freq_y, grid_y) * width_y
			+ wavenum_sq(it.freq_z, grid_z) * width_z;
		g = (longint'(fft_gain) * gauss_exp_q16(acc >> 1) + 64'd32768) >> 16;
		if (g > 64'hFFFF_FFFF)
			g = 64'hFFFF_FFFF;
		r.out_re = scale_part(it.coef_re, g);
		r.out_im = scale_part(it.coef_im, g);
		return r;
	endfunction

	task automatic report_mismatch(input string msg);
		if (mismatches < 40)
			$display("%0t ns: %s", $time, msg);
		mismatches++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		sgg_out_t want;
		if (!arst_n) begin
			grid_x   = 13'd256;
			grid_y   = 13'd256;
			grid_z   = 13'd256;
			width_x  = '0;
			width_y  = '0;
			width_z  = '0;
			fft_gain = '1;
			filtered_q.delete();
			pending <= 0;
		end else begin
			if (done) begin
				if (filtered_q.size() == 0) begin
					report_mismatch($sformatf("result %h with no item outstanding", result));
				end else begin
					want = filtered_q.pop_front();
					if (result.out_re !== want.out_re)
						report_mismatch($sformatf("out_re %h, expected %h",
							result.out_re, want.out_re));
					if (result.out_im !== want.out_im)
						report_mismatch($sformatf("out_im %h, expected %h",
							result.out_im, want.out_im));
				end
			end
			if (start && !busy)
				filtered_q.push_back(filter_coef(sample));
			if (cfg_we) begin
				case (cfg_index)
					REG_GRID_X:  grid_x   = cfg_data[GRID_W-1:0];
					REG_GRID_Y:  grid_y   = cfg_data[GRID_W-1:0];
					REG_GRID_Z:  grid_z   = cfg_data[GRID_W-1:0];
					REG_WIDTH_X: width_x  = cfg_data;
					REG_WIDTH_Y: width_y  = cfg_data;
					REG_WIDTH_Z: width_z  = cfg_data;
					REG_GAIN:    fft_gain = cfg_data;
					default: ;
				endcase
			end
			pending <= filtered_q.size();
		end
	end

endmodule

>>> verif/spectral_gaussian_gain_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spectral_gaussian_gain_tb: stimulus and verdict for the Gaussian gain block
// Directed items on the folding boundaries, the saturation threshold and the
// coefficient extremes, then random items over a series of register settings
// with the sender idling at different rates. Checking is done by the checker.
// ----------------------------------------------------------------------------
module spectral_gaussian_gain_tb;
	import sgg_pkg::*;

	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;
	localparam int DRAIN_CYCLES = 20;
	localparam int ITEMS_PER_PHASE = 200;

	logic                 clk;
	logic                 arst_n;
	logic                 start;
	logic                 busy;
	sgg_in_t              sample;
	logic                 done;
	sgg_out_t             result;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [DATA_W-1:0]    cfg_data;
	int                   errors;
	int                   pending;

	int                   idle_pct;
	logic [GRID_W-1:0]    grid_n [3];

	spectral_gaussian_gain dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.sample    (sample),
		.done      (done),
		.result    (result),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	spectral_gaussian_gain_checker checker_i (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.sample    (sample),
		.done      (done),
		.result    (result),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.errors    (errors),
		.pending   (pending)
	);

	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	initial begin
		#2_000_000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	// each cycle is left idle with probability idle_pct percent before the item goes out
	task automatic send_item(input sgg_in_t it);
		while ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
		sample <= it;
		start  <= 1'b1;
		@(posedge clk);
		while (busy)
			@(posedge clk);
	endtask

	task automatic send_fields(input logic [FREQ_W-1:0] fx, input logic [FREQ_W-1:0] fy,
			input logic [FREQ_W-1:0] fz, input logic [DATA_W-1:0] re,
			input logic [DATA_W-1:0] im);
		sgg_in_t it;
		it.freq_x  = fx;
		it.freq_y  = fy;
		it.freq_z  = fz;
		it.coef_re = re;
		it.coef_im = im;
		send_item(it);
	endtask

	task automatic drain();
		start <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DATA_W-1:0] val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		if (idx == REG_GRID_X || idx == REG_GRID_Y || idx == REG_GRID_Z)
			grid_n[idx] = val[GRID_W-1:0];
		@(posedge clk);
	endtask

	task automatic apply_setting(input logic [GRID_W-1:0] gx, input logic [GRID_W-1:0] gy,
			input logic [GRID_W-1:0] gz, input logic [31:0] wx, input logic [31:0] wy,
			input logic [31:0] wz, input logic [31:0] gain);
		write_reg(REG_GRID_X, 32'(gx));
		write_reg(REG_GRID_Y, 32'(gy));
		write_reg(REG_GRID_Z, 32'(gz));
		write_reg(REG_WIDTH_X, wx);
		write_reg(REG_WIDTH_Y, wy);
		write_reg(REG_WIDTH_Z, wz);
		write_reg(REG_GAIN, gain);
		cfg_we <= 1'b0;
	endtask

	// small wavenumbers and the folding points are where the shaping happens
	function automatic logic [FREQ_W-1:0] pick_freq(logic [GRID_W-1:0] n);
		logic [GRID_W-1:0] nn;
		nn = (n > MAX_GRID_SIZE) ? GRID_W'(MAX_GRID_SIZE) : n;
		case ($urandom_range(3))
			0: return FREQ_W'($urandom_range(4095));
			1: return FREQ_W'($urandom_range(15));
			2: return FREQ_W'(nn + $urandom_range(16) - 8);
			default: return FREQ_W'((nn >> 1) + $urandom_range(4) - 2);
		endcase
	endfunction

	function automatic logic [DATA_W-1:0] pick_coef();
		case ($urandom_range(9))
			0: return 32'h7FFF_FFFF;
			1: return 32'h8000_0000;
			default: return $urandom;
		endcase
	endfunction

	initial begin
		logic [GRID_W-1:0] rg [3];
		logic [31:0]       rw [3];
		logic [31:0]       rgain;
		int                mode, phase, i, n;

		arst_n    = 1'b0;
		start     = 1'b0;
		sample    = '0;
		cfg_we    = 1'b0;
		cfg_index = REG_GRID_X;
		cfg_data  = '0;
		idle_pct  = 18;
		grid_n    = '{13'd256, 13'd256, 13'd256};
		repeat (5)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// registers at reset: no attenuation, gain just below one
		send_fields(12'd0, 12'd0, 12'd0, 32'h7FFF_FFFF, 32'h8000_0000);
		send_fields(12'd4095, 12'd4095, 12'd4095, 32'h0, 32'hFFFF_FFFF);
		send_fields(12'd128, 12'd129, 12'd256, 32'h1, 32'h4000_0000);
		send_fields(12'd255, 12'd1, 12'd2048, 32'h8000_0000, 32'h7FFF_FFFF);

		drain();
		apply_setting(13'd256, 13'd8191, 13'd0, 32'd2 << 24, 32'd1 << 24, 32'd1 << 20,
			32'hFFFF_FFFF);
		send_fields(12'd4, 12'd0, 12'd0, 32'h4000_0000, 32'hC000_0000);   // s exactly 16
		send_fields(12'd3, 12'd0, 12'd0, 32'h4000_0000, 32'hC000_0000);
		send_fields(12'd252, 12'd0, 12'd0, 32'h7FFF_FFFF, 32'h8000_0000);
		send_fields(12'd253, 12'd0, 12'd0, 32'h7FFF_FFFF, 32'h8000_0000);
		send_fields(12'd128, 12'd0, 12'd0, 32'h7FFF_FFFF, 32'h8000_0000);
		send_fields(12'd0, 12'd1, 12'd0, 32'h7FFF_FFFF, 32'h8000_0000);
		send_fields(12'd0, 12'd4095, 12'd0, 32'h1234_5678, 32'h8765_4321);
		send_fields(12'd0, 12'd2048, 12'd0, 32'h7FFF_FFFF, 32'h8000_0000);
		send_fields(12'd0, 12'd0, 12'd4095, 32'h7FFF_FFFF, 32'h8000_0000);
		send_fields(12'd0, 12'd0, 12'd1, 32'h7FFF_FFFF, 32'h8000_0000);
		send_fields(12'd1, 12'd1, 12'd1, 32'hFFFF_FFFF, 32'h0000_0001);
		send_fields(12'd0, 12'd0, 12'd0, 32'h8000_0000, 32'h7FFF_FFFF);

		for (mode = 0; mode < 3; mode++) begin
			idle_pct = (mode == 0) ? 18 : (mode == 1) ? 61 : 0;
			for (phase = 0; phase < 3; phase++) begin
				drain();
				case (mode * 3 + phase)
					0: apply_setting(13'd1, 13'd4096, 13'd8191, 32'hFFFF_FFFF, 32'd1 << 20,
						32'd0, 32'h8000_0000);
					1: begin
						write_reg(REG_UNUSED, $urandom);
						apply_setting(13'd0, 13'd5000, 13'd2, 32'd1 << 16, 32'd1 << 16,
							32'd1 << 16, 32'd0);
					end
					2: apply_setting(13'd4096, 13'd4096, 13'd4096, 32'd1 << 10, 32'd1 << 10,
						32'd1 << 10, 32'hFFFF_FFFF);
					default: begin
						for (i = 0; i < 3; i++) begin
							case ($urandom_range(9))
								0: rg[i] = '0;
								1: rg[i] = GRID_W'($urandom_range(4097, 8191));
								default: rg[i] = GRID_W'($urandom_range(1, 4096));
							endcase
							case ($urandom_range(9))
								0: rw[i] = '0;
								1: rw[i] = '1;
								default: rw[i] = $urandom >> $urandom_range(31);
							endcase
						end
						case ($urandom_range(9))
							0: rgain = '0;
							1: rgain = '1;
							default: rgain = $urandom;
						endcase
						apply_setting(rg[0], rg[1], rg[2], rw[0], rw[1], rw[2], rgain);
					end
				endcase
				for (n = 0; n < ITEMS_PER_PHASE; n++)
					send_fields(pick_freq(grid_n[0]), pick_freq(grid_n[1]),
						pick_freq(grid_n[2]), pick_coef(), pick_coef());
			end
		end

		drain();
		repeat (DRAIN_CYCLES)
			@(posedge clk);
		if (errors == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

>>> spectral_gaussian_gain.f
hw/rtl/sgg_pkg.sv
hw/rtl/sgg_exp.sv
hw/rtl/spectral_gaussian_gain.sv
verif/spectral_gaussian_gain_checker.sv
verif/spectral_gaussian_gain_tb.sv
